### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at each rising clock edge outside reset.
`define ASSERT_CLKD(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/tdpt_pkg.sv
`default_nettype none

package tdpt_pkg;

	// The first odd trial divisor and its square.
	localparam int unsigned FIRST_DIVISOR = 3;
	localparam int unsigned FIRST_SQUARE  = 9;

	// The only even prime.
	localparam int unsigned EVEN_PRIME = 2;

endpackage

`default_nettype wire

### rtl/trial_division_prime_test_unit.sv
// Channel   | Signals                  | Handshake
// ----------+--------------------------+------------------------------------------
// command   | start, candidate         | accepted when start is high, busy low
// result    | done, is_prime           | done high for one cycle, no back-pressure
//
// One transaction runs at a time. The candidate is classified first; every odd
// trial divisor then costs one bound check against the running square and
// one bit-serial remainder step per bit.
// Reset clears the controller and the result strobe; done cannot be stalled.
`default_nettype none

`include "assert_macros.svh"

module trial_division_prime_test_unit #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [VALUE_WIDTH-1:0] candidate,
	output logic                               busy,
	output logic                               done,
	output logic                               is_prime
);

	import tdpt_pkg::*;

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_CHECK,
		ST_DIVIDE
	} state_t;

	state_t          state_q;
	logic [W-1:0]    value_q;
	logic [W-1:0]    shift_q;
	logic [W-1:0]    divisor_q;
	logic [W-1:0]    square_q;
	logic [W-1:0]    rem_q;
	logic [CW-1:0]   bit_cnt_q;
	logic            done_q;
	logic            prime_q;

	logic [W:0]      rem_shift;
	logic [W:0]      rem_diff;
	logic            rem_ge;
	logic [W-1:0]    rem_next;
	logic [W-1:0]    square_next;

	// Restoring remainder step: bring in the next bit of the value, subtract
	// the divisor when it fits.
	assign rem_shift   = {rem_q, shift_q[W-1]};
	assign rem_ge      = rem_shift >= {1'b0, divisor_q};
	assign rem_diff    = rem_shift - {1'b0, divisor_q};
	assign rem_next    = rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0];

	// Square of the next odd divisor: (d + 2)^2 = d^2 + 4d + 4.
	assign square_next = square_q + {divisor_q[W-3:0], 2'b00} + W'(4);

	// Controller, trial state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			prime_q   <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						value_q <= candidate;
						state_q <= ST_CLASSIFY;
					end
				end
				ST_CLASSIFY: begin
					if (value_q[W-1] || value_q < W'(EVEN_PRIME)) begin
						prime_q <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (value_q == W'(EVEN_PRIME)) begin
						prime_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (!value_q[0]) begin
						prime_q <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						divisor_q <= W'(FIRST_DIVISOR);
						square_q  <= W'(FIRST_SQUARE);
						state_q   <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (square_q > value_q) begin
						prime_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						shift_q   <= value_q;
						rem_q     <= '0;
						bit_cnt_q <= '0;
						state_q   <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					rem_q     <= rem_next;
					shift_q   <= {shift_q[W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + CW'(1);
					if (bit_cnt_q == CW'(W - 1)) begin
						if (rem_next == '0) begin
							prime_q <= 1'b0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							divisor_q <= divisor_q + W'(2);
							square_q  <= square_next;
							state_q   <= ST_CHECK;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign is_prime = prime_q;

	// An accepted transaction always makes the unit busy in the next cycle.
	`ASSERT_CLKD(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not start")
	// A result is only delivered at the end of a transaction.
	`ASSERT_CLKD(a_done_after_busy, done |-> (!busy && $past(busy)), "result without transaction")
	// The partial remainder stays below the divisor during a trial.
	`ASSERT_CLKD(a_rem_bound, (state_q == ST_DIVIDE) |-> (rem_q < divisor_q), "remainder overflow")
	// Trial divisors are odd and at least three.
	`ASSERT_NEVER(a_divisor_odd, (state_q == ST_DIVIDE) && !divisor_q[0], "even trial divisor")

endmodule

`default_nettype wire
